/* hdl/tld_pkg.sv */
// Shared constants, codes and controller/datapath structs of the tty line discipline.
package tld_pkg;

  localparam int LINE_DEPTH  = 1024;
  localparam int QUEUE_DEPTH = 1024;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int LEN_W       = LINE_AW + 1;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = QUEUE_AW + 1;

  localparam logic [LEN_W-1:0]  LINE_FULL  = LEN_W'(LINE_DEPTH);
  localparam logic [FILL_W-1:0] QUEUE_FULL = FILL_W'(QUEUE_DEPTH);

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_EMPTY = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic accept;     // capture the incoming item
    logic line_push;  // append the item character to the line store
    logic line_pop;   // drop the last line character
    logic line_clr;   // empty the line store
    logic push_key;   // pass the item character into the queue
    logic q_rd;       // start a read of the queue head
    logic pop;        // retire the queue head as the read result
    logic set_empty;  // result is an empty-queue report
    logic mv_run;     // one step of moving the line into the queue
    logic load_out;   // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic pressed;
    logic ch_zero;
    logic is_nl;
    logic is_bs;
    logic line_mode;
    logic line_empty;
    logic q_empty;
    logic mv_done;
    logic slot_free;
  } dp_sts_t;

endpackage

/* hdl/tld_if.sv */
// Channel interfaces of the tty line discipline: input items, results and configuration.
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       key_pressed;
  logic [7:0] key_char;
  modport source(output valid, cmd, key_pressed, key_char, input ready);
  modport sink(input valid, cmd, key_pressed, key_char, output ready);
endinterface

interface tld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       overflow;
  modport source(output valid, result_kind, data_byte, overflow, input ready);
  modport sink(input valid, result_kind, data_byte, overflow, output ready);
endinterface

interface tld_cfg_if;
  logic valid;
  logic ready;
  logic line_mode;
  modport source(output valid, line_mode, input ready);
  modport sink(input valid, line_mode, output ready);
endinterface

/* hdl/tld_datapath.sv */
// Datapath: line store, input queue, pointers, result and output registers.
module tld_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tld_pkg::ctrl_cmd_t  cmd,
  output tld_pkg::dp_sts_t    sts,
  input  logic                in_cmd,
  input  logic                in_key_pressed,
  input  logic [7:0]          in_key_char,
  input  logic                cfg_valid,
  input  logic                cfg_line_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_result_kind,
  output logic [7:0]          out_data_byte,
  output logic                out_overflow
);

  logic [7:0] line_mem [tld_pkg::LINE_DEPTH];
  logic [7:0] queue_mem [tld_pkg::QUEUE_DEPTH];

  logic                        item_cmd_r;
  logic                        item_pressed_r;
  logic [7:0]                  item_ch_r;
  logic                        line_mode_r;
  logic [tld_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [tld_pkg::LEN_W-1:0]    mv_idx_r, mv_idx_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [tld_pkg::QUEUE_AW-1:0] head_r, head_nxt;
  logic [tld_pkg::FILL_W-1:0]   fill_r, fill_nxt;
  logic                        ovf_r, ovf_nxt;
  tld_pkg::result_kind_t       kind_r, kind_nxt;
  logic [7:0]                  data_r, data_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tld_pkg::result_kind_t       out_kind_r;
  logic [7:0]                  out_data_r;
  logic                        out_ovf_r;

  logic [7:0]                  line_rd_r;
  logic [7:0]                  queue_rd_r;
  logic                        line_we, line_rd_en, queue_we, queue_rd_en;
  logic                        push_en;
  logic [7:0]                  push_data;
  logic [tld_pkg::FILL_W-1:0]   tail_sum, tail_wrap;
  logic [tld_pkg::QUEUE_AW-1:0] tail;
  logic                        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Tail of the ring: head plus fill, folded back once past the end.
  always_comb begin
    tail_sum = {1'b0, head_r} + fill_r;
    if (tail_sum >= tld_pkg::QUEUE_FULL) begin
      tail_wrap = tail_sum - tld_pkg::QUEUE_FULL;
    end else begin
      tail_wrap = tail_sum;
    end
    tail = tail_wrap[tld_pkg::QUEUE_AW-1:0];
  end

  always_comb begin
    len_nxt     = len_r;
    mv_idx_nxt  = mv_idx_r;
    rd_pend_nxt = rd_pend_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    kind_nxt    = kind_r;
    data_nxt    = data_r;
    line_we     = 1'b0;
    line_rd_en  = 1'b0;
    queue_we    = 1'b0;
    queue_rd_en = 1'b0;

    if (cmd.accept) begin
      ovf_nxt     = 1'b0;
      kind_nxt    = tld_pkg::KIND_ECHO;
      data_nxt    = in_key_char;
      mv_idx_nxt  = '0;
      rd_pend_nxt = 1'b0;
    end

    if (cmd.line_push) begin
      if (len_r >= tld_pkg::LINE_FULL) begin
        ovf_nxt = 1'b1;
      end else begin
        line_we = 1'b1;
        len_nxt = len_r + 1'b1;
      end
    end
    if (cmd.line_pop) begin
      len_nxt = len_r - 1'b1;
    end
    if (cmd.line_clr) begin
      len_nxt = '0;
    end

    // A line move issues one store read per cycle; the byte read in the
    // previous cycle is pushed into the queue in this one.
    if (cmd.mv_run) begin
      if (mv_idx_r < len_r) begin
        line_rd_en  = 1'b1;
        mv_idx_nxt  = mv_idx_r + 1'b1;
        rd_pend_nxt = 1'b1;
      end else begin
        rd_pend_nxt = 1'b0;
      end
    end

    push_en   = cmd.push_key || (cmd.mv_run && rd_pend_r);
    push_data = cmd.push_key ? item_ch_r : line_rd_r;
    if (push_en) begin
      if (fill_r >= tld_pkg::QUEUE_FULL) begin
        ovf_nxt = 1'b1;
      end else begin
        queue_we = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end

    if (cmd.q_rd) begin
      queue_rd_en = 1'b1;
    end
    if (cmd.pop) begin
      kind_nxt = tld_pkg::KIND_READ;
      data_nxt = queue_rd_r;
      fill_nxt = fill_r - 1'b1;
      if (head_r == tld_pkg::QUEUE_AW'(tld_pkg::QUEUE_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
    end
    if (cmd.set_empty) begin
      kind_nxt = tld_pkg::KIND_EMPTY;
      data_nxt = '0;
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[len_r[tld_pkg::LINE_AW-1:0]] <= item_ch_r;
    end
    if (line_rd_en) begin
      line_rd_r <= line_mem[mv_idx_r[tld_pkg::LINE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (queue_we) begin
      queue_mem[tail] <= push_data;
    end
    if (queue_rd_en) begin
      queue_rd_r <= queue_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r <= 1'b1;
      len_r       <= '0;
      mv_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        line_mode_r <= cfg_line_mode;
      end
      len_r       <= len_nxt;
      mv_idx_r    <= mv_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd_r     <= in_cmd;
      item_pressed_r <= in_key_pressed;
      item_ch_r      <= in_key_char;
    end
    ovf_r  <= ovf_nxt;
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    if (cmd.load_out) begin
      out_kind_r <= kind_r;
      out_data_r <= data_r;
      out_ovf_r  <= ovf_r;
    end
  end

  always_comb begin
    sts.is_read    = (item_cmd_r == tld_pkg::CMD_READ);
    sts.pressed    = item_pressed_r;
    sts.ch_zero    = (item_ch_r == 8'h00);
    sts.is_nl      = (item_ch_r == tld_pkg::CH_NEWLINE);
    sts.is_bs      = (item_ch_r == tld_pkg::CH_BACKSPACE);
    sts.line_mode  = line_mode_r;
    sts.line_empty = (len_r == '0);
    sts.q_empty    = (fill_r == '0);
    sts.mv_done    = !(mv_idx_r < len_r) && !rd_pend_r;
    sts.slot_free  = slot_free;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_data_byte   = out_data_r;
  assign out_overflow    = out_ovf_r;

endmodule

/* hdl/tld_ctrl.sv */
// Controller state machine: decodes each item and sequences the datapath.
module tld_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tld_pkg::dp_sts_t   sts,
  output tld_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_DECODE    = 5'b00010,
    S_READ_WAIT = 5'b00100,
    S_MOVE      = 5'b01000,
    S_FINISH    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_read) begin
          if (sts.q_empty) begin
            cmd.set_empty = 1'b1;
            state_nxt     = S_FINISH;
          end else begin
            cmd.q_rd  = 1'b1;
            state_nxt = S_READ_WAIT;
          end
        end else if (!sts.pressed || sts.ch_zero) begin
          state_nxt = S_IDLE;
        end else if (!sts.line_mode) begin
          cmd.push_key = 1'b1;
          state_nxt    = S_FINISH;
        end else if (sts.is_nl) begin
          cmd.line_push = 1'b1;
          state_nxt     = S_MOVE;
        end else if (sts.is_bs) begin
          if (sts.line_empty) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.line_pop = 1'b1;
            state_nxt    = S_FINISH;
          end
        end else begin
          cmd.line_push = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_READ_WAIT: begin
        cmd.pop   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_MOVE: begin
        if (sts.mv_done) begin
          cmd.line_clr = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.mv_run = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/tty_line_discipline.sv */
// Top level of the tty line discipline: controller, datapath and channel hookup.
//
//   channel  dir  payload                                  transfer when
//   in_ch    in   cmd, key_pressed, key_char               valid && ready
//   out_ch   out  result_kind, data_byte, overflow         valid && ready
//   cfg_ch   in   line_mode                                valid (ready tied high)
//
// Items are taken one at a time. A newline moves the line into the queue with one
// store read and one queue write per cycle.
// Reset is synchronous; there is no clearing pass, both stores start undefined.
// The output register lets in_ch take the next item while a result waits; an item
// that finishes while the output register is still full holds until it drains.
module tty_line_discipline (
  input  logic       clk,
  input  logic       rst_n,
  tld_in_if.sink     in_ch,
  tld_out_if.source  out_ch,
  tld_cfg_if.sink    cfg_ch
);

  tld_pkg::ctrl_cmd_t cmd;
  tld_pkg::dp_sts_t   sts;

  assign cfg_ch.ready = 1'b1;

  tld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tld_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_ch.cmd),
    .in_key_pressed  (in_ch.key_pressed),
    .in_key_char     (in_ch.key_char),
    .cfg_valid       (cfg_ch.valid),
    .cfg_line_mode   (cfg_ch.line_mode),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_result_kind (out_ch.result_kind),
    .out_data_byte   (out_ch.data_byte),
    .out_overflow    (out_ch.overflow)
  );

endmodule

/* sim/tld_checker.sv */
// Checker for tty_line_discipline: mirrors the line store and input queue and checks each result.
`timescale 1ns / 100ps
module tld_checker (
  input  logic clk,
  input  logic rst_n,
  tld_in_if    in_ch,
  tld_out_if   out_ch,
  tld_cfg_if   cfg_ch,
  output int   errors,
  output int   results_owed
);

  typedef struct {
    tld_pkg::result_kind_t kind;
    logic [7:0]            data;
    logic                  ovf;
  } tty_result_t;

  logic [7:0]                   line_buf [tld_pkg::LINE_DEPTH];
  logic [tld_pkg::LEN_W-1:0]    line_len;
  logic [7:0]                   rx_queue [tld_pkg::QUEUE_DEPTH];
  logic [tld_pkg::QUEUE_AW-1:0] rx_head;
  logic [tld_pkg::FILL_W-1:0]   rx_fill;
  logic                         canon_mode;

  tty_result_t results_due[$];
  int          fails = 0;
  int          owed  = 0;

  assign errors       = fails;
  assign results_owed = owed;

  function automatic logic rx_put(input logic [7:0] b);
    logic [tld_pkg::QUEUE_AW-1:0] tail;
    if (rx_fill >= tld_pkg::QUEUE_FULL) return 1'b1;
    tail = rx_head + tld_pkg::QUEUE_AW'(rx_fill);
    rx_queue[tail] = b;
    rx_fill++;
    return 1'b0;
  endfunction

  function automatic logic line_put(input logic [7:0] b);
    if (line_len >= tld_pkg::LINE_FULL) return 1'b1;
    line_buf[line_len[tld_pkg::LINE_AW-1:0]] = b;
    line_len++;
    return 1'b0;
  endfunction

  // Applies one accepted item to the mirrored state and records the result it owes.
  task automatic discipline_step(input logic c, input logic pressed, input logic [7:0] ch);
    tty_result_t r;
    logic        answers;
    int          i;
    r.kind  = tld_pkg::KIND_ECHO;
    r.data  = ch;
    r.ovf   = 1'b0;
    answers = 1'b1;
    if (c == tld_pkg::CMD_READ) begin
      if (rx_fill == '0) begin
        r.kind = tld_pkg::KIND_EMPTY;
        r.data = 8'h00;
      end else begin
        r.kind = tld_pkg::KIND_READ;
        r.data = rx_queue[rx_head];
        rx_head++;
        rx_fill--;
      end
    end else if (!pressed || ch == 8'h00) begin
      answers = 1'b0;
    end else if (!canon_mode) begin
      r.ovf = rx_put(ch);
    end else if (ch == tld_pkg::CH_NEWLINE) begin
      // A full line still moves; only the newline itself is lost.
      r.ovf = line_put(ch);
      for (i = 0; i < int'(line_len); i++)
        r.ovf |= rx_put(line_buf[i[tld_pkg::LINE_AW-1:0]]);
      line_len = '0;
    end else if (ch == tld_pkg::CH_BACKSPACE) begin
      if (line_len == '0) answers = 1'b0;
      else line_len--;
    end else begin
      r.ovf = line_put(ch);
    end
    if (answers) results_due.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    tty_result_t want;
    if (!rst_n) begin
      line_len   = '0;
      rx_head    = '0;
      rx_fill    = '0;
      canon_mode = 1'b1;
      results_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: result_kind %0d, data_byte %0h, overflow %0b",
                 out_ch.result_kind, out_ch.data_byte, out_ch.overflow);
          fails++;
        end else begin
          want = results_due[0];
          results_due.delete(0);
          if (out_ch.result_kind !== want.kind) begin
            $error("result_kind mismatch: expected %0d, actual %0d",
                   want.kind, out_ch.result_kind);
            fails++;
          end
          if (out_ch.data_byte !== want.data) begin
            $error("data_byte mismatch: expected %0h, actual %0h", want.data, out_ch.data_byte);
            fails++;
          end
          if (out_ch.overflow !== want.ovf) begin
            $error("overflow mismatch: expected %0b, actual %0b", want.ovf, out_ch.overflow);
            fails++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) canon_mode = cfg_ch.line_mode;
      if (in_ch.valid && in_ch.ready)
        discipline_step(in_ch.cmd, in_ch.key_pressed, in_ch.key_char);
    end
    owed <= results_due.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for tty_line_discipline: stimulus, result back-pressure, timeout and verdict.
`timescale 1ns / 100ps
module tb;

  // Longest item is a newline moving a full line, plus output register slack.
  localparam int SETTLE_CYCLES = tld_pkg::LINE_DEPTH + 80;
  localparam int CYCLE_LIMIT   = 2_000_000;

  logic clk;
  logic rst_n;
  int   errors;
  int   results_owed;
  int   cycles = 0;
  int   sent   = 0;
  bit   idle_on = 1'b1;

  tld_in_if  in_ch ();
  tld_out_if out_ch ();
  tld_cfg_if cfg_ch ();

  tty_line_discipline dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tld_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .errors       (errors),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tty_line_discipline verification failed");
      $finish;
    end
  end

  // Result side: random stall before each transfer while idling is enabled.
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic offer_item(input logic c, input logic pressed, input logic [7:0] ch);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.key_pressed <= pressed;
    in_ch.key_char    <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic key(input logic [7:0] ch);
    offer_item(tld_pkg::CMD_KEY, 1'b1, ch);
  endtask

  task automatic host_read();
    offer_item(tld_pkg::CMD_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Stop sending, wait for every owed result, then let any silent item finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_mode(input logic mode);
    settle();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.line_mode <= mode;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255));
    while (ch == tld_pkg::CH_NEWLINE || ch == tld_pkg::CH_BACKSPACE);
    return ch;
  endfunction

  // A line with random content, some edits and stray releases, closed by a newline.
  task automatic type_line(input int len);
    int pick;
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) key(tld_pkg::CH_BACKSPACE);
      else if (pick < 20) offer_item(tld_pkg::CMD_KEY, 1'b0, 8'($urandom_range(0, 255)));
      else key(plain_char());
    end
    key(tld_pkg::CH_NEWLINE);
  endtask

  initial begin : stimulus
    int last_cfg;
    int pick;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= tld_pkg::CMD_KEY;
    in_ch.key_pressed <= 1'b0;
    in_ch.key_char    <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.line_mode  <= 1'b1;
    rst_n             <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Line mode after reset: edits, empty-line backspace, ignored keys, empty reads.
    offer_item(tld_pkg::CMD_READ, 1'b1, 8'hFF);
    offer_item(tld_pkg::CMD_KEY, 1'b0, 8'h61);
    offer_item(tld_pkg::CMD_KEY, 1'b1, 8'h00);
    key(tld_pkg::CH_BACKSPACE);
    key(8'hFF);
    key(8'h01);
    key(8'h41);
    key(tld_pkg::CH_BACKSPACE);
    key(8'h80);
    key(tld_pkg::CH_NEWLINE);
    offer_item(tld_pkg::CMD_READ, 1'b0, 8'h00);
    offer_item(tld_pkg::CMD_READ, 1'b1, 8'hAA);
    repeat (3) host_read();
    offer_item(tld_pkg::CMD_KEY, 1'b0, tld_pkg::CH_NEWLINE);

    // Pass-through: backspace and newline are ordinary bytes.
    set_line_mode(1'b0);
    key(8'h78);
    key(tld_pkg::CH_BACKSPACE);
    key(tld_pkg::CH_NEWLINE);
    offer_item(tld_pkg::CMD_KEY, 1'b0, 8'h7A);
    offer_item(tld_pkg::CMD_KEY, 1'b1, 8'h00);
    repeat (4) host_read();

    // Back-to-back run without idling: pass-through keys, then a long line.
    idle_on = 1'b0;
    repeat (20) key(plain_char());
    set_line_mode(1'b1);
    repeat (30) key(plain_char());
    key(tld_pkg::CH_BACKSPACE);
    key(tld_pkg::CH_NEWLINE);
    repeat (56) host_read();
    settle();

    // Random traffic with occasional mode changes.
    idle_on  = 1'b1;
    last_cfg = sent;
    while (sent < 400) begin
      if (sent - last_cfg >= 90) begin
        last_cfg = sent;
        set_line_mode(1'($urandom_range(0, 1)));
        idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) type_line($urandom_range(0, 12));
      else if (pick < 80) repeat ($urandom_range(1, 15)) host_read();
      else repeat ($urandom_range(1, 4))
        offer_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)));
    end

    settle();
    if (errors == 0 && results_owed == 0) begin
      $display("tty_line_discipline verification clean");
    end else begin
      $display("tty_line_discipline verification failed");
    end
    $finish;
  end

endmodule
